>>> rtl/smd_pkg.sv
package smd_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int FLOOR_W     = 10;
    localparam int CMP_W       = (SP_W > FLOOR_W) ? SP_W : FLOOR_W;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 4;
    localparam int TGT_W       = 10;
    localparam int STATUS_W    = 3;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [SP_W-1:0] SP_TOP = SP_W'(STACK_DEPTH - 1);

    typedef logic [CMD_W-1:0]    t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_PUSH  = 4'd0;
    localparam t_op OP_ADD   = 4'd1;
    localparam t_op OP_SUB   = 4'd2;
    localparam t_op OP_MUL   = 4'd3;
    localparam t_op OP_DIV   = 4'd4;
    localparam t_op OP_MOD   = 4'd5;
    localparam t_op OP_BGT   = 4'd6;
    localparam t_op OP_BGE   = 4'd7;
    localparam t_op OP_BLT   = 4'd8;
    localparam t_op OP_BLE   = 4'd9;
    localparam t_op OP_BEQ   = 4'd10;
    localparam t_op OP_BNE   = 4'd11;
    localparam t_op OP_PRINT = 4'd12;
    localparam t_op OP_HALT  = 4'd13;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_OP    = 3'd1;
    localparam t_status ST_DIV_ZERO  = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_POP_EMPTY = 3'd4;

    typedef struct packed {
        logic latch;
        logic pop;
        logic cap_tos;
        logic calc;
        logic div_start;
        logic div_cap;
        logic push;
        logic set_halt;
        logic bad_op;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic halted;
        logic tos_zero;
        logic div_done;
        logic out_busy;
    } t_dp_stat;

    function automatic logic is_arith(input t_op op);
        return (op >= OP_ADD) && (op <= OP_MOD);
    endfunction

    function automatic logic is_branch(input t_op op);
        return (op >= OP_BGT) && (op <= OP_BNE);
    endfunction

    function automatic logic is_divop(input t_op op);
        return (op == OP_DIV) || (op == OP_MOD);
    endfunction

endpackage

>>> rtl/smd_div.sv
module smd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [smd_pkg::DATA_W-1:0] i_dividend,
    input  logic [smd_pkg::DATA_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [smd_pkg::DATA_W-1:0] o_quot,
    output logic [smd_pkg::DATA_W-1:0] o_rem
);

    localparam int W = smd_pkg::DATA_W;

    logic                           r_busy;
    logic                           r_done;
    logic [smd_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [W-1:0]                   r_quo;
    logic [W-1:0]                   r_rem;
    logic [W-1:0]                   r_den;
    logic                           r_neg_q;
    logic                           r_neg_r;
    logic [W:0]                     shifted;
    logic [W:0]                     diff;
    logic [W-1:0]                   n_quo;
    logic [W-1:0]                   n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        diff    = shifted - {1'b0, r_den};
        if (!diff[W]) begin
            n_rem = diff[W-1:0];
            n_quo = {r_quo[W-2:0], 1'b1};
        end else begin
            n_rem = shifted[W-1:0];
            n_quo = {r_quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == smd_pkg::DIV_CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo   <= i_dividend[W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_den   <= i_divisor[W-1] ? (~i_divisor + 1'b1) : i_divisor;
            r_rem   <= '0;
            r_neg_q <= i_dividend[W-1] ^ i_divisor[W-1];
            r_neg_r <= i_dividend[W-1];
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg_q ? (~r_quo + 1'b1) : r_quo;
    assign o_rem  = r_neg_r ? (~r_rem + 1'b1) : r_rem;

endmodule

>>> rtl/smd_datapath.sv
module smd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  smd_pkg::t_dp_cmd              i_ctrl,
    output smd_pkg::t_dp_stat             o_stat,
    input  logic [smd_pkg::CMD_W-1:0]     i_cmd,
    input  logic signed [smd_pkg::DATA_W-1:0] i_immediate,
    input  logic                          i_cfg_we,
    input  logic [smd_pkg::FLOOR_W-1:0]   i_cfg_wdata,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_print_valid,
    output logic signed [smd_pkg::DATA_W-1:0] o_print_value,
    output logic                          o_branch_taken,
    output logic [smd_pkg::TGT_W-1:0]     o_branch_target,
    output logic                          o_halted,
    output logic [smd_pkg::STATUS_W-1:0]  o_status
);

    localparam int W = smd_pkg::DATA_W;

    logic [W-1:0]                  r_mem [smd_pkg::STACK_DEPTH];
    logic [W-1:0]                  r_rd_data;
    logic                          r_rd_ok;
    logic [smd_pkg::SP_W-1:0]      r_sp;
    logic [smd_pkg::FLOOR_W-1:0]   r_floor;
    logic                          r_halt;
    smd_pkg::t_op                  r_op;
    logic [W-1:0]                  r_imm;
    logic [W-1:0]                  r_tos;
    logic [W-1:0]                  r_res;
    logic                          r_pv;
    logic                          r_taken;
    smd_pkg::t_status              r_fault;
    logic                          r_out_valid;
    logic                          r_o_pv;
    logic [W-1:0]                  r_o_pval;
    logic                          r_o_taken;
    logic [smd_pkg::TGT_W-1:0]     r_o_tgt;
    logic                          r_o_halted;
    smd_pkg::t_status              r_o_status;

    logic                          empty;
    logic                          full;
    logic                          rd_en;
    logic                          wr_en;
    logic [smd_pkg::SP_W-1:0]      addr;
    logic [W-1:0]                  push_val;
    logic [W-1:0]                  sos;
    logic                          cond;
    smd_pkg::t_status              fault_evt;
    logic                          div_done;
    logic [W-1:0]                  div_quot;
    logic [W-1:0]                  div_rem;

    assign empty    = (r_sp >= smd_pkg::SP_TOP);
    assign full     = (smd_pkg::CMP_W'(r_sp) <= smd_pkg::CMP_W'(r_floor));
    assign rd_en    = i_ctrl.pop && !empty;
    assign wr_en    = i_ctrl.push && !full;
    assign addr     = i_ctrl.push ? r_sp : (r_sp + 1'b1);
    assign push_val = (r_op == smd_pkg::OP_PUSH) ? r_imm : r_res;
    assign sos      = r_rd_ok ? r_rd_data : '0;

    always_comb begin
        case (r_op)
            smd_pkg::OP_BGT: cond = $signed(sos) >  $signed(r_tos);
            smd_pkg::OP_BGE: cond = $signed(sos) >= $signed(r_tos);
            smd_pkg::OP_BLT: cond = $signed(sos) <  $signed(r_tos);
            smd_pkg::OP_BLE: cond = $signed(sos) <= $signed(r_tos);
            smd_pkg::OP_BEQ: cond = (sos == r_tos);
            smd_pkg::OP_BNE: cond = (sos != r_tos);
            default:         cond = 1'b0;
        endcase
    end

    always_comb begin
        fault_evt = smd_pkg::ST_OK;
        if (i_ctrl.pop && empty) begin
            fault_evt = smd_pkg::ST_POP_EMPTY;
        end
        if (i_ctrl.bad_op) begin
            fault_evt = smd_pkg::ST_BAD_OP;
        end
        if (i_ctrl.calc && smd_pkg::is_divop(r_op) && (r_tos == '0)) begin
            fault_evt = smd_pkg::ST_DIV_ZERO;
        end
        if (i_ctrl.push && full) begin
            fault_evt = smd_pkg::ST_FULL;
        end
    end

    smd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.div_start),
        .i_dividend (sos),
        .i_divisor  (r_tos),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[addr] <= push_val;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= smd_pkg::SP_TOP;
            r_floor     <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_floor <= i_cfg_wdata;
            end
            if (rd_en) begin
                r_sp <= r_sp + 1'b1;
            end else if (wr_en) begin
                r_sp <= r_sp - 1'b1;
            end
            if (i_ctrl.set_halt) begin
                r_halt <= 1'b1;
            end
            if (i_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_op    <= i_cmd;
            r_imm   <= i_immediate;
            r_tos   <= '0;
            r_pv    <= 1'b0;
            r_taken <= 1'b0;
            r_fault <= smd_pkg::ST_OK;
        end else if (r_fault == smd_pkg::ST_OK) begin
            r_fault <= fault_evt;
        end
        if (i_ctrl.pop) begin
            r_rd_ok <= !empty;
        end
        if (i_ctrl.cap_tos) begin
            r_tos <= sos;
            r_pv  <= (r_op == smd_pkg::OP_PRINT);
        end
        if (i_ctrl.calc) begin
            r_taken <= smd_pkg::is_branch(r_op) && cond;
            case (r_op)
                smd_pkg::OP_ADD: r_res <= sos + r_tos;
                smd_pkg::OP_SUB: r_res <= sos - r_tos;
                smd_pkg::OP_MUL: r_res <= W'(sos * r_tos);
                default:         r_res <= '0;
            endcase
        end
        if (i_ctrl.div_cap) begin
            r_res <= (r_op == smd_pkg::OP_DIV) ? div_quot : div_rem;
        end
        if (i_ctrl.load_out) begin
            r_o_pv     <= r_pv;
            r_o_pval   <= r_pv ? r_tos : '0;
            r_o_taken  <= r_taken;
            r_o_tgt    <= r_taken ? r_imm[smd_pkg::TGT_W-1:0] : '0;
            r_o_halted <= r_halt;
            r_o_status <= r_fault;
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.halted   = r_halt;
    assign o_stat.tos_zero = (r_tos == '0);
    assign o_stat.div_done = div_done;
    assign o_stat.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_print_valid   = r_o_pv;
    assign o_print_value   = r_o_pval;
    assign o_branch_taken  = r_o_taken;
    assign o_branch_target = r_o_tgt;
    assign o_halted        = r_o_halted;
    assign o_status        = r_o_status;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    a_halted_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_halted) |->
            (!r_o_pv && !r_o_taken && (r_o_status == smd_pkg::ST_OK)))
        else $error("halted beat carries other results");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.div_start |-> (r_tos != '0))
        else $error("divider started with zero divisor");

endmodule

>>> rtl/smd_ctrl.sv
module smd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  smd_pkg::t_dp_stat  i_stat,
    output smd_pkg::t_dp_cmd   o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP1,
        S_POP2,
        S_CALC,
        S_DIV,
        S_PUSH,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_ctrl  = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.latch = 1'b1;
                    n_state      = S_POP1;
                end
            end
            S_POP1: begin
                if (i_stat.halted) begin
                    n_state = S_FIN;
                end else if (i_stat.op == smd_pkg::OP_PUSH) begin
                    n_state = S_PUSH;
                end else if (smd_pkg::is_arith(i_stat.op) || smd_pkg::is_branch(i_stat.op)
                             || (i_stat.op == smd_pkg::OP_PRINT)) begin
                    o_ctrl.pop = 1'b1;
                    n_state    = S_POP2;
                end else if (i_stat.op == smd_pkg::OP_HALT) begin
                    o_ctrl.set_halt = 1'b1;
                    n_state         = S_FIN;
                end else begin
                    o_ctrl.bad_op = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_POP2: begin
                o_ctrl.cap_tos = 1'b1;
                if (i_stat.op == smd_pkg::OP_PRINT) begin
                    n_state = S_FIN;
                end else begin
                    o_ctrl.pop = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_ctrl.calc = 1'b1;
                if (smd_pkg::is_branch(i_stat.op)) begin
                    n_state = S_FIN;
                end else if (smd_pkg::is_divop(i_stat.op) && !i_stat.tos_zero) begin
                    o_ctrl.div_start = 1'b1;
                    n_state          = S_DIV;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_ctrl.div_cap = 1'b1;
                    n_state        = S_PUSH;
                end
            end
            S_PUSH: begin
                o_ctrl.push = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.load_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> rtl/stack_machine_execute_unit.sv
// Push writes the stack; add, sub, mul pop two, compute and push; compare-branch
// pops two and compares; print pops one; halt, unknown opcode and any item after
// halt go straight to the result; div and mod run the divider before the push,
// skipped on a zero divisor. One item in flight: the next beat is taken once the
// result is registered, which a stalled output holds off; the pace is set by the
// single-port stack memory (one pop or push a cycle) and one-bit-a-cycle divider.
// Synchronous active-low reset: empty stack, halt clear, floor 0; stack contents
// are not cleared.
module stack_machine_execute_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [smd_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [smd_pkg::DATA_W-1:0] i_immediate,
    input  logic                              i_cfg_we,
    input  logic [smd_pkg::FLOOR_W-1:0]       i_cfg_wdata,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_print_valid,
    output logic signed [smd_pkg::DATA_W-1:0] o_print_value,
    output logic                              o_branch_taken,
    output logic [smd_pkg::TGT_W-1:0]         o_branch_target,
    output logic                              o_halted,
    output logic [smd_pkg::STATUS_W-1:0]      o_status
);

    smd_pkg::t_dp_cmd  ctrl;
    smd_pkg::t_dp_stat stat;

    smd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    smd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .o_stat          (stat),
        .i_cmd           (i_cmd),
        .i_immediate     (i_immediate),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_print_valid   (o_print_valid),
        .o_print_value   (o_print_value),
        .o_branch_taken  (o_branch_taken),
        .o_branch_target (o_branch_target),
        .o_halted        (o_halted),
        .o_status        (o_status)
    );

endmodule
